>>> rtl/rcmv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Region colour majority vote: shared types and constants
// Pixel and result transaction types, class codes, register indexes, reset
// values and the front sequencer states.
// ----------------------------------------------------------------------------
package rcmv_pkg;

  // One pixel transaction on the input side.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_pixel;
  } pix_t;

  // Width of the count field on the result side.
  localparam int OUT_COUNT_W   = 13;
  localparam int OUT_COUNT_MAX = 2 ** OUT_COUNT_W - 1;

  // One result transaction on the output side.
  typedef struct packed {
    logic [2:0]             majority_colour;
    logic [OUT_COUNT_W-1:0] winning_count;
  } res_t;

  localparam int NUM_CLASSES = 6;
  localparam int NUM_REFS    = 5;

  // Class codes.
  typedef logic [2:0] class_t;
  localparam class_t CLS_WHITE  = 3'd0;
  localparam class_t CLS_YELLOW = 3'd1;
  localparam class_t CLS_GREEN  = 3'd2;
  localparam class_t CLS_BLUE   = 3'd3;
  localparam class_t CLS_RED    = 3'd4;
  localparam class_t CLS_ORANGE = 3'd5;

  // Classified pixel passed from the front to the vote logic.
  typedef struct packed {
    class_t cls;
    logic   last;
  } vote_t;

  localparam int QUEUE_DEPTH = 2;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_WHITE_SAT_MAX = 3'd0;
  localparam cfg_idx_t CFG_WHITE_VAL_MIN = 3'd1;
  localparam cfg_idx_t CFG_YELLOW_HUE    = 3'd2;
  localparam cfg_idx_t CFG_GREEN_HUE     = 3'd3;
  localparam cfg_idx_t CFG_BLUE_HUE      = 3'd4;
  localparam cfg_idx_t CFG_RED_HUE       = 3'd5;
  localparam cfg_idx_t CFG_ORANGE_HUE    = 3'd6;

  // Hue values in degrees.
  typedef logic [8:0] hue_t;
  localparam hue_t HUE_FULL   = 9'd360;
  localparam hue_t HUE_BASE_R = 9'd0;
  localparam hue_t HUE_BASE_G = 9'd120;
  localparam hue_t HUE_BASE_B = 9'd240;

  // Register reset values.
  localparam logic [7:0] WHITE_SAT_RST = 8'd38;
  localparam logic [7:0] WHITE_VAL_RST = 8'd217;
  localparam hue_t REF_HUE_RST [NUM_REFS] = '{9'd60, 9'd120, 9'd240, 9'd0, 9'd30};

  // Hue divider: the rounded quotient never exceeds 60, so six bits suffice.
  localparam int QUO_W = 6;
  localparam int DIV_W = 14;

  // Front sequencer states.
  typedef enum logic [2:0] {
    FS_IDLE,
    FS_CALC,
    FS_DIV,
    FS_FIX,
    FS_CLASS,
    FS_PUSH
  } front_state_t;

endpackage

>>> rtl/region_colour_majority_vote.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Region colour majority vote
// Classifies region pixels by hue, saturation and value and returns the
// majority class and its count on the last pixel of each region.
// ----------------------------------------------------------------------------
// The front takes a new pixel only after the last one is pushed to the queue;
//   white pixels skip the hue divider and the reference hue search, grey ones
//   skip the divider only.
// A two-entry queue lets the front keep classifying while the vote logic waits.
// Reset: synchronous, active low; restores register defaults, clears the vote
//   and empties the queue and result register.
module region_colour_majority_vote import rcmv_pkg::*; #(
  parameter int COUNT_WIDTH = 13
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  output logic                  full,
  input  pix_t                  in_data,
  output logic                  empty,
  input  logic                  pop,
  output res_t                  out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  cfg_idx_t              cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic  fq_push, fq_full, qb_pop, qb_empty;
  vote_t fq_data, qb_data;

  // Pixel classifier front.
  rcmv_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_push    (fq_push),
    .q_data    (fq_data),
    .q_full    (fq_full)
  );

  // Queue of classified pixels.
  rcmv_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_push  (fq_push),
    .wr_data  (fq_data),
    .wr_full  (fq_full),
    .rd_pop   (qb_pop),
    .rd_data  (qb_data),
    .rd_empty (qb_empty)
  );

  // Vote counters and result register.
  rcmv_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (qb_empty),
    .q_data   (qb_data),
    .q_pop    (qb_pop),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

endmodule

>>> rtl/rcmv_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Region colour majority vote: pixel classifier front
// Accepts pixels, converts them to hue, saturation and value, and finds the
// class of each pixel with an iterative hue divider and a one-reference-per-
// cycle nearest hue search. Holds the configuration registers.
// ----------------------------------------------------------------------------
module rcmv_front import rcmv_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  output logic                  full,
  input  pix_t                  in_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  cfg_idx_t              cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  q_push,
  output vote_t                 q_data,
  input  logic                  q_full
);

  front_state_t     state_r, state_nxt;
  pix_t             pix_r, pix_nxt;
  logic [7:0]       sat_max_r;
  logic [7:0]       val_min_r;
  hue_t             ref_r [NUM_REFS];
  hue_t             base_r, base_nxt;
  logic             neg_r, neg_nxt;
  logic [DIV_W-1:0] rem_r, rem_nxt;
  logic [DIV_W-1:0] dvs_r, dvs_nxt;
  logic [QUO_W-1:0] quo_r, quo_nxt;
  logic [2:0]       step_r, step_nxt;
  hue_t             hue_r, hue_nxt;
  class_t           cls_r, cls_nxt;
  logic [9:0]       dist_r, dist_nxt;
  logic [2:0]       ref_idx_r, ref_idx_nxt;

  // Conversion and search terms.
  logic [7:0]        mx, mn, d_calc, abs_num;
  logic [15:0]       sat_lhs;
  logic [8:0]        sat_lim;
  logic [16:0]       sat_rhs;
  logic              is_white;
  logic signed [8:0] num;
  hue_t              base_sel;
  logic [DIV_W-1:0]  mag;
  logic              ge;
  logic signed [10:0] q_signed, hue_signed;
  logic signed [10:0] ref_s, hue_s, full_s;
  logic [9:0]        e1, e2, e3, dist_cur;

  function automatic logic [9:0] abs11(input logic signed [10:0] v);
    abs11 = v[10] ? 10'(-v) : v[9:0];
  endfunction

  // The configuration port never stalls.
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sat_max_r <= WHITE_SAT_RST;
      val_min_r <= WHITE_VAL_RST;
      for (int i = 0; i < NUM_REFS; i++) begin
        ref_r[i] <= REF_HUE_RST[i];
      end
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_WHITE_SAT_MAX: sat_max_r <= cfg_data[7:0];
        CFG_WHITE_VAL_MIN: val_min_r <= cfg_data[7:0];
        CFG_YELLOW_HUE:    ref_r[0]  <= cfg_data;
        CFG_GREEN_HUE:     ref_r[1]  <= cfg_data;
        CFG_BLUE_HUE:      ref_r[2]  <= cfg_data;
        CFG_RED_HUE:       ref_r[3]  <= cfg_data;
        CFG_ORANGE_HUE:    ref_r[4]  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Colour conversion terms from the held pixel.
  always_comb begin
    mx = pix_r.red;
    if (pix_r.green > mx) mx = pix_r.green;
    if (pix_r.blue > mx) mx = pix_r.blue;
    mn = pix_r.red;
    if (pix_r.green < mn) mn = pix_r.green;
    if (pix_r.blue < mn) mn = pix_r.blue;
    d_calc = mx - mn;

    // floor(255*d/mx) <= limit holds exactly when 255*d < (limit+1)*mx.
    sat_lhs  = {d_calc, 8'h00} - {8'h00, d_calc};
    sat_lim  = {1'b0, sat_max_r} + 9'd1;
    sat_rhs  = sat_lim * mx;
    is_white = (mx >= val_min_r) && ((mx == 8'd0) || ({1'b0, sat_lhs} < sat_rhs));

    // Sector of the hue circle picked by the largest component.
    priority if (mx == pix_r.red) begin
      base_sel = HUE_BASE_R;
      num      = $signed({1'b0, pix_r.green}) - $signed({1'b0, pix_r.blue});
    end else if (mx == pix_r.green) begin
      base_sel = HUE_BASE_G;
      num      = $signed({1'b0, pix_r.blue}) - $signed({1'b0, pix_r.red});
    end else begin
      base_sel = HUE_BASE_B;
      num      = $signed({1'b0, pix_r.red}) - $signed({1'b0, pix_r.green});
    end
    abs_num = num[8] ? 8'(-num) : num[7:0];
    // 60*|num| plus half the divisor, for rounding halves away from zero.
    mag = (DIV_W'(abs_num) << 6) - (DIV_W'(abs_num) << 2) + DIV_W'(d_calc[7:1]);
  end

  // Divider step, hue fix-up and distance to the current reference.
  always_comb begin
    ge       = (rem_r >= dvs_r);
    q_signed = neg_r ? -$signed({5'b0, quo_r}) : $signed({5'b0, quo_r});
    hue_signed = $signed({2'b0, base_r}) + q_signed;
    full_s   = $signed({2'b0, HUE_FULL});
    if (hue_signed < 0) hue_signed = hue_signed + full_s;

    ref_s = $signed({2'b0, ref_r[ref_idx_r]});
    hue_s = $signed({2'b0, hue_r});
    e1 = abs11(ref_s - hue_s);
    e2 = abs11(ref_s + full_s - hue_s);
    e3 = abs11(ref_s - full_s - hue_s);
    dist_cur = e1;
    if (e2 < dist_cur) dist_cur = e2;
    if (e3 < dist_cur) dist_cur = e3;
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    pix_r     <= pix_nxt;
    base_r    <= base_nxt;
    neg_r     <= neg_nxt;
    rem_r     <= rem_nxt;
    dvs_r     <= dvs_nxt;
    quo_r     <= quo_nxt;
    step_r    <= step_nxt;
    hue_r     <= hue_nxt;
    cls_r     <= cls_nxt;
    dist_r    <= dist_nxt;
    ref_idx_r <= ref_idx_nxt;
  end

  // Sequencer: next state and datapath updates.
  always_comb begin
    state_nxt   = state_r;
    pix_nxt     = pix_r;
    base_nxt    = base_r;
    neg_nxt     = neg_r;
    rem_nxt     = rem_r;
    dvs_nxt     = dvs_r;
    quo_nxt     = quo_r;
    step_nxt    = step_r;
    hue_nxt     = hue_r;
    cls_nxt     = cls_r;
    dist_nxt    = dist_r;
    ref_idx_nxt = ref_idx_r;
    full        = (state_r != FS_IDLE);
    q_push      = 1'b0;
    q_data.cls  = cls_r;
    q_data.last = pix_r.last_pixel;

    unique case (state_r)
      FS_IDLE: begin
        if (push) begin
          pix_nxt   = in_data;
          state_nxt = FS_CALC;
        end
      end
      FS_CALC: begin
        base_nxt    = base_sel;
        neg_nxt     = num[8];
        rem_nxt     = mag;
        dvs_nxt     = DIV_W'(d_calc) << (QUO_W - 1);
        quo_nxt     = '0;
        step_nxt    = 3'(QUO_W - 1);
        hue_nxt     = '0;
        ref_idx_nxt = '0;
        priority if (is_white) begin
          cls_nxt   = CLS_WHITE;
          state_nxt = FS_PUSH;
        end else if (d_calc == 8'd0) begin
          // A grey pixel has hue zero.
          state_nxt = FS_CLASS;
        end else begin
          state_nxt = FS_DIV;
        end
      end
      FS_DIV: begin
        // Restoring division, one quotient bit per cycle.
        if (ge) rem_nxt = rem_r - dvs_r;
        quo_nxt = {quo_r[QUO_W-2:0], ge};
        dvs_nxt = dvs_r >> 1;
        if (step_r == 3'd0) begin
          state_nxt = FS_FIX;
        end else begin
          step_nxt = step_r - 3'd1;
        end
      end
      FS_FIX: begin
        hue_nxt   = hue_signed[8:0];
        state_nxt = FS_CLASS;
      end
      FS_CLASS: begin
        // Strict compare keeps the lower class on a tie.
        if ((ref_idx_r == 3'd0) || (dist_cur < dist_r)) begin
          dist_nxt = dist_cur;
          cls_nxt  = class_t'(ref_idx_r + 3'd1);
        end
        if (ref_idx_r == 3'(NUM_REFS - 1)) begin
          state_nxt = FS_PUSH;
        end else begin
          ref_idx_nxt = ref_idx_r + 3'd1;
        end
      end
      FS_PUSH: begin
        q_push = 1'b1;
        if (!q_full) state_nxt = FS_IDLE;
      end
      default: begin
        state_nxt = FS_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/rcmv_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Region colour majority vote: classified pixel queue
// A short FIFO between the classifier front and the vote logic.
// ----------------------------------------------------------------------------
module rcmv_queue import rcmv_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  wr_push,
  input  vote_t wr_data,
  output logic  wr_full,
  input  logic  rd_pop,
  output vote_t rd_data,
  output logic  rd_empty
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

  vote_t            mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_wr, do_rd;

  assign wr_full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign rd_empty = (count_r == '0);
  assign do_wr    = wr_push && !wr_full;
  assign do_rd    = rd_pop && !rd_empty;
  assign rd_data  = mem_r[rd_ptr_r];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    if (do_rd) rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    if (do_wr && !do_rd) count_nxt = count_r + 1'b1;
    if (do_rd && !do_wr) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wr_ptr_r] <= wr_data;
  end

endmodule

>>> rtl/rcmv_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Region colour majority vote: vote counters and result register
// Counts classified pixels in saturating counters, tracks the running
// winner, and on the last pixel of a region loads the result register and
// clears the vote.
// ----------------------------------------------------------------------------
module rcmv_back import rcmv_pkg::*; #(
  parameter int COUNT_WIDTH = 13
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  q_empty,
  input  vote_t q_data,
  output logic  q_pop,
  output logic  empty,
  input  logic  pop,
  output res_t  out_data
);

  localparam int WIDE_W = (COUNT_WIDTH > OUT_COUNT_W) ? COUNT_WIDTH : OUT_COUNT_W;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX      = '1;
  localparam logic [WIDE_W-1:0]      OUT_MAX_WIDE = WIDE_W'(OUT_COUNT_MAX);

  logic [COUNT_WIDTH-1:0] counts_r [NUM_CLASSES];
  logic [COUNT_WIDTH-1:0] best_cnt_r, best_cnt_nxt;
  class_t                 best_cls_r, best_cls_nxt;
  logic                   out_valid_r, out_valid_nxt;
  res_t                   out_data_r, out_data_nxt;

  logic                   take;
  logic [COUNT_WIDTH-1:0] cur_cnt, inc_cnt;
  logic [WIDE_W-1:0]      best_wide;

  // A last pixel needs a result register that is free or being popped; other pixels never wait.
  assign take     = !q_empty && (!q_data.last || !out_valid_r || pop);
  assign q_pop    = take;
  assign empty    = !out_valid_r;
  assign out_data = out_data_r;

  // Counter update and running winner.
  always_comb begin
    cur_cnt      = counts_r[q_data.cls];
    inc_cnt      = (cur_cnt == CNT_MAX) ? cur_cnt : cur_cnt + 1'b1;
    best_cnt_nxt = best_cnt_r;
    best_cls_nxt = best_cls_r;
    if (inc_cnt > best_cnt_r) begin
      best_cnt_nxt = inc_cnt;
      best_cls_nxt = q_data.cls;
    end
    best_wide = WIDE_W'(best_cnt_nxt);

    out_data_nxt.majority_colour = best_cls_nxt;
    out_data_nxt.winning_count   = (best_wide > OUT_MAX_WIDE) ?
                                   OUT_MAX_WIDE[OUT_COUNT_W-1:0] :
                                   best_wide[OUT_COUNT_W-1:0];

    out_valid_nxt = out_valid_r;
    if (take && q_data.last) begin
      out_valid_nxt = 1'b1;
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Vote state, cleared after each region.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        counts_r[i] <= '0;
      end
      best_cnt_r  <= '0;
      best_cls_r  <= CLS_WHITE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (take) begin
        if (q_data.last) begin
          for (int i = 0; i < NUM_CLASSES; i++) begin
            counts_r[i] <= '0;
          end
          best_cnt_r <= '0;
          best_cls_r <= CLS_WHITE;
        end else begin
          counts_r[q_data.cls] <= inc_cnt;
          best_cnt_r           <= best_cnt_nxt;
          best_cls_r           <= best_cls_nxt;
        end
      end
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (take && q_data.last) out_data_r <= out_data_nxt;
  end

  // A finished region always leaves a cleared vote behind.
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    take && q_data.last |=> (best_cnt_r == '0) && (best_cls_r == CLS_WHITE))
    else $error("vote not cleared after last pixel");

  // Within a region the best count never falls.
  a_best_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    take && !q_data.last |=> best_cnt_r >= $past(best_cnt_r))
    else $error("best count decreased within a region");

  // A last pixel taken from the queue always yields a result.
  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    take && q_data.last |=> out_valid_r)
    else $error("result missing after last pixel");

endmodule
